// File: hdl/cfsq_pkg.sv
`timescale 1ns / 1ps
package cfsq_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int VAL_W         = 31;
    localparam int LARGEST_W     = 32;
    localparam int NIB_W         = 4;

    localparam logic signed [LARGEST_W-1:0] NONE_LARGEST = -32'sd1;

    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_POP   = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic issue;
        logic load_out;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic rem_zero;
        logic rd_vld;
    } t_sts;

endpackage

// File: hdl/cfsq_ram.sv
`timescale 1ns / 1ps
module cfsq_ram #(
    parameter  int WIDTH = 31,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/cfsq_ctrl.sv
`timescale 1ns / 1ps
module cfsq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cfsq_pkg::t_ctl o_ctl,
    input  cfsq_pkg::t_sts i_sts
);

    cfsq_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfsq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = cfsq_pkg::ST_SCAN;
            end
            cfsq_pkg::ST_SCAN: begin
                if (i_sts.rem_zero && !i_sts.rd_vld) n_state = cfsq_pkg::ST_OUT;
            end
            cfsq_pkg::ST_OUT: begin
                if (out_free) n_state = cfsq_pkg::ST_IDLE;
            end
            default: n_state = cfsq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl.start    = 1'b0;
        o_ctl.issue    = 1'b0;
        o_ctl.load_out = 1'b0;
        unique case (r_state)
            cfsq_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctl.start = i_in_valid;
            end
            cfsq_pkg::ST_SCAN: begin
                o_ctl.issue = !i_sts.rem_zero;
            end
            cfsq_pkg::ST_OUT: begin
                o_ctl.load_out = out_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfsq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/cfsq_dp.sv
`timescale 1ns / 1ps
module cfsq_dp #(
    parameter int SLOTS = cfsq_pkg::SLOTS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cfsq_pkg::t_ctl                        i_ctl,
    output cfsq_pkg::t_sts                        o_sts,
    input  logic [1:0]                            i_command,
    input  logic [cfsq_pkg::VAL_W-1:0]            i_value,
    output logic                                  o_accepted,
    output logic [cfsq_pkg::NIB_W-1:0]            o_occupancy,
    output logic                                  o_is_empty,
    output logic                                  o_is_full,
    output logic [cfsq_pkg::VAL_W-1:0]            o_head_value,
    output logic signed [cfsq_pkg::LARGEST_W-1:0] o_largest,
    output logic                                  o_key_present,
    output logic [cfsq_pkg::NIB_W-1:0]            o_key_count
);

    localparam int PW = $clog2(SLOTS);
    localparam int CW = (PW > cfsq_pkg::NIB_W) ? PW : cfsq_pkg::NIB_W;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        ring_next = (p == PW'(SLOTS - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ring_occ(input logic [PW-1:0] f, input logic [PW-1:0] b);
        ring_occ = (b - f) + ((b < f) ? PW'(SLOTS) : '0);
    endfunction

    logic [PW-1:0]                r_front, n_front;
    logic [PW-1:0]                r_back, n_back;
    logic [PW-1:0]                r_rd_ptr;
    logic [PW-1:0]                r_rem;
    logic                         r_rd_vld;
    logic [cfsq_pkg::VAL_W-1:0]   r_key;
    logic                         r_acc;
    logic [PW-1:0]                r_occ;
    logic                         r_have;
    logic [cfsq_pkg::VAL_W-1:0]   r_head;
    logic [cfsq_pkg::VAL_W-1:0]   r_best;
    logic [PW-1:0]                r_matches;

    logic                         push_ok, pop_ok;
    logic                         full_now, empty_now;
    logic [PW-1:0]                rd_addr;
    logic [cfsq_pkg::VAL_W-1:0]   rd_data;
    logic [CW-1:0]                occ_ext, match_ext;

    logic                                  r_o_accepted;
    logic [cfsq_pkg::NIB_W-1:0]            r_o_occupancy;
    logic                                  r_o_is_empty;
    logic                                  r_o_is_full;
    logic [cfsq_pkg::VAL_W-1:0]            r_o_head_value;
    logic signed [cfsq_pkg::LARGEST_W-1:0] r_o_largest;
    logic                                  r_o_key_present;
    logic [cfsq_pkg::NIB_W-1:0]            r_o_key_count;

    assign full_now  = (ring_next(r_back) == r_front);
    assign empty_now = (r_front == r_back);

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        push_ok = 1'b0;
        pop_ok  = 1'b0;
        if (i_ctl.start) begin
            unique case (i_command)
                cfsq_pkg::CMD_PUSH: begin
                    push_ok = !full_now;
                    if (!full_now) n_back = ring_next(r_back);
                end
                cfsq_pkg::CMD_POP: begin
                    pop_ok = !empty_now;
                    if (!empty_now) n_front = ring_next(r_front);
                end
                default: ;  // query only, and the spare code
            endcase
        end
    end

    assign rd_addr = ring_next(r_rd_ptr);

    cfsq_ram #(
        .WIDTH (cfsq_pkg::VAL_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (n_back),
        .i_wdata (i_value),
        .i_re    (i_ctl.issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= PW'(SLOTS - 1);
            r_back   <= PW'(SLOTS - 1);
            r_rem    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_front  <= n_front;
            r_back   <= n_back;
            r_rd_vld <= i_ctl.issue;
            if (i_ctl.start) begin
                r_rem <= ring_occ(n_front, n_back);
            end else if (i_ctl.issue) begin
                r_rem <= r_rem - PW'(1);
            end
        end
    end

    // scan walks from the oldest entry; read data lands in the cycle after the issue
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rd_ptr  <= n_front;
            r_key     <= i_value;
            r_acc     <= push_ok || pop_ok;
            r_occ     <= ring_occ(n_front, n_back);
            r_have    <= 1'b0;
            r_head    <= '0;
            r_best    <= '0;
            r_matches <= '0;
        end else begin
            if (i_ctl.issue) begin
                r_rd_ptr <= rd_addr;
            end
            if (r_rd_vld) begin
                r_have <= 1'b1;
                if (!r_have) begin
                    r_head <= rd_data;
                    r_best <= rd_data;
                end else if (rd_data > r_best) begin
                    r_best <= rd_data;
                end
                if (rd_data == r_key) begin
                    r_matches <= r_matches + PW'(1);
                end
            end
        end
    end

    assign occ_ext   = CW'(r_occ);
    assign match_ext = CW'(r_matches);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_o_accepted    <= r_acc;
            r_o_occupancy   <= occ_ext[cfsq_pkg::NIB_W-1:0];
            r_o_is_empty    <= empty_now;
            r_o_is_full     <= full_now;
            r_o_head_value  <= r_head;
            r_o_largest     <= r_have ? $signed({1'b0, r_best}) : cfsq_pkg::NONE_LARGEST;
            r_o_key_present <= (r_matches != '0);
            r_o_key_count   <= match_ext[cfsq_pkg::NIB_W-1:0];
        end
    end

    assign o_sts.rem_zero = (r_rem == '0);
    assign o_sts.rd_vld   = r_rd_vld;

    assign o_accepted    = r_o_accepted;
    assign o_occupancy   = r_o_occupancy;
    assign o_is_empty    = r_o_is_empty;
    assign o_is_full     = r_o_is_full;
    assign o_head_value  = r_o_head_value;
    assign o_largest     = r_o_largest;
    assign o_key_present = r_o_key_present;
    assign o_key_count   = r_o_key_count;

endmodule

// File: hdl/circular_fifo_with_scan_queries_core.sv
// Circular FIFO of SLOTS entries (one kept free) with scan queries.
// Input channel (i_in_valid / o_in_ready) carries a command and a 31-bit value:
// query only, push the value, or pop the head. Each beat yields one result beat
// on the output channel (o_out_valid / i_out_ready): whether the push or pop
// took effect, occupancy, empty and full flags, the head value, the largest
// stored value (-1 when empty) and how many stored entries equal the value.
// The stored entries are read one per cycle through the single read port of
// the slot RAM, and the result is moved into the output register once the
// scan is through.
// One item is in work at a time; the next input beat is taken as soon as the
// result has been moved into the output register, even if it is not yet taken.
// A stalled receiver holds the result in that register and the block waits
// with o_in_ready low once the following result is ready.
// Reset (i_rst_n low, synchronous) empties the FIFO and drops any pending
// result; the slot RAM is not cleared, as empty slots are never read.
`timescale 1ns / 1ps
module circular_fifo_with_scan_queries_core #(
    parameter int SLOTS = cfsq_pkg::SLOTS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_command,
    input  logic [cfsq_pkg::VAL_W-1:0]            i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_accepted,
    output logic [cfsq_pkg::NIB_W-1:0]            o_occupancy,
    output logic                                  o_is_empty,
    output logic                                  o_is_full,
    output logic [cfsq_pkg::VAL_W-1:0]            o_head_value,
    output logic signed [cfsq_pkg::LARGEST_W-1:0] o_largest,
    output logic                                  o_key_present,
    output logic [cfsq_pkg::NIB_W-1:0]            o_key_count
);

    cfsq_pkg::t_ctl ctl;
    cfsq_pkg::t_sts sts;

    cfsq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    cfsq_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_accepted    (o_accepted),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_head_value  (o_head_value),
        .o_largest     (o_largest),
        .o_key_present (o_key_present),
        .o_key_count   (o_key_count)
    );

    // one item in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |->
            (o_largest == cfsq_pkg::NONE_LARGEST && o_head_value == '0 && !o_key_present))
        else $error("empty FIFO reported stored data");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_full && o_is_empty))
        else $error("FIFO reported both full and empty");

    a_scan_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.issue |-> !sts.rem_zero)
        else $error("slot read issued past the newest entry");

endmodule

// File: sim/cfsq_result_check.sv
`timescale 1ns / 1ps
module cfsq_result_check #(
    parameter int SLOTS = cfsq_pkg::SLOTS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic [1:0]                            i_command,
    input  logic [cfsq_pkg::VAL_W-1:0]            i_value,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic                                  i_accepted,
    input  logic [cfsq_pkg::NIB_W-1:0]            i_occupancy,
    input  logic                                  i_is_empty,
    input  logic                                  i_is_full,
    input  logic [cfsq_pkg::VAL_W-1:0]            i_head_value,
    input  logic signed [cfsq_pkg::LARGEST_W-1:0] i_largest,
    input  logic                                  i_key_present,
    input  logic [cfsq_pkg::NIB_W-1:0]            i_key_count,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    localparam int VAL_W     = cfsq_pkg::VAL_W;
    localparam int NIB_W     = cfsq_pkg::NIB_W;
    localparam int LARGEST_W = cfsq_pkg::LARGEST_W;

    typedef struct packed {
        logic                        accepted;
        logic [NIB_W-1:0]            occupancy;
        logic                        is_empty;
        logic                        is_full;
        logic [VAL_W-1:0]            head_value;
        logic signed [LARGEST_W-1:0] largest;
        logic                        key_present;
        logic [NIB_W-1:0]            key_count;
    } t_fifo_status;

    // front_ptr sits one slot before the oldest entry, back_ptr on the newest
    logic [VAL_W-1:0] ring [SLOTS];
    int unsigned      front_ptr;
    int unsigned      back_ptr;

    t_fifo_status     status_q [$];
    t_fifo_status     want;
    int               fail_total = 0;

    function automatic int unsigned ring_next(input int unsigned p);
        return (p < SLOTS - 1) ? p + 1 : 0;
    endfunction

    function automatic t_fifo_status apply_command(input logic [1:0] cmd,
                                                   input logic [VAL_W-1:0] key);
        t_fifo_status r;
        int unsigned  p;
        int unsigned  held;
        int unsigned  hits;
        logic         have;
        r       = '0;
        held    = 0;
        hits    = 0;
        have    = 1'b0;
        if (cmd == cfsq_pkg::CMD_PUSH) begin
            if (ring_next(back_ptr) != front_ptr) begin
                back_ptr       = ring_next(back_ptr);
                ring[back_ptr] = key;
                r.accepted     = 1'b1;
            end
        end else if (cmd == cfsq_pkg::CMD_POP) begin
            if (front_ptr != back_ptr) begin
                front_ptr  = ring_next(front_ptr);
                r.accepted = 1'b1;
            end
        end
        // code 3 falls through as a plain query
        r.largest = cfsq_pkg::NONE_LARGEST;
        p = front_ptr;
        while (p != back_ptr) begin
            p = ring_next(p);
            if (held == 0)
                r.head_value = ring[p];
            held++;
            if (!have || ring[p] > r.largest[VAL_W-1:0]) begin
                r.largest = {1'b0, ring[p]};
                have      = 1'b1;
            end
            if (ring[p] == key)
                hits++;
        end
        r.occupancy   = held[NIB_W-1:0];
        r.is_empty    = (front_ptr == back_ptr);
        r.is_full     = (ring_next(back_ptr) == front_ptr);
        r.key_present = (hits != 0);
        r.key_count   = hits[NIB_W-1:0];
        return r;
    endfunction

    task automatic note_field(input string field, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            fail_total++;
            if (fail_total <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h",
                         $realtime, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_ptr = SLOTS - 1;
            back_ptr  = SLOTS - 1;
            status_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                status_q.push_back(apply_command(i_command, i_value));
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result beat with nothing outstanding", $realtime);
                end else begin
                    want = status_q.pop_front();
                    note_field("accepted", want.accepted, i_accepted);
                    note_field("occupancy", want.occupancy, i_occupancy);
                    note_field("is_empty", want.is_empty, i_is_empty);
                    note_field("is_full", want.is_full, i_is_full);
                    note_field("head_value", want.head_value, i_head_value);
                    note_field("largest", want.largest, i_largest);
                    note_field("key_present", want.key_present, i_key_present);
                    note_field("key_count", want.key_count, i_key_count);
                end
            end
        end
        o_fail_count = fail_total;
        o_pending    = status_q.size();
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int          VAL_W        = cfsq_pkg::VAL_W;
    localparam int          NIB_W        = cfsq_pkg::NIB_W;
    localparam int          LARGEST_W    = cfsq_pkg::LARGEST_W;
    localparam int          SLOTS        = cfsq_pkg::SLOTS_DEFAULT;
    localparam logic [1:0]  CMD_SPARE    = 2'd3;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;
    localparam int          FILL_ITEMS   = SLOTS - 1;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          TOTAL_ITEMS  = FILL_ITEMS + 7 + RANDOM_ITEMS;
    localparam int          TAIL_FROM    = TOTAL_ITEMS - 100;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          STALL_LIMIT  = 2000;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic [1:0]                  command   = cfsq_pkg::CMD_QUERY;
    logic [VAL_W-1:0]            value     = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        accepted;
    logic [NIB_W-1:0]            occupancy;
    logic                        is_empty;
    logic                        is_full;
    logic [VAL_W-1:0]            head_value;
    logic signed [LARGEST_W-1:0] largest;
    logic                        key_present;
    logic [NIB_W-1:0]            key_count;
    int                          fail_count;
    int                          pending;
    int                          sent      = 0;
    int                          quiet     = 0;

    always #5 clk = ~clk;

    circular_fifo_with_scan_queries_core #(.SLOTS(SLOTS)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_command(command), .i_value(value),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_accepted(accepted), .o_occupancy(occupancy),
        .o_is_empty(is_empty), .o_is_full(is_full),
        .o_head_value(head_value), .o_largest(largest),
        .o_key_present(key_present), .o_key_count(key_count)
    );

    cfsq_result_check #(.SLOTS(SLOTS)) u_result_check (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_command(command), .i_value(value),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_accepted(accepted), .i_occupancy(occupancy),
        .i_is_empty(is_empty), .i_is_full(is_full),
        .i_head_value(head_value), .i_largest(largest),
        .i_key_present(key_present), .i_key_count(key_count),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // offer one beat, hold it until taken, then maybe drop valid for a short burst
    task automatic send_item(input logic [1:0] cmd, input logic [VAL_W-1:0] val);
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do @(posedge clk); while (!in_ready);
        sent++;
        if (sent < TAIL_FROM && (sent / 40) % 3 != 0 && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    initial begin : stimulus
        int               k;
        int               push_bias;
        int               pool;
        int               pick;
        logic [1:0]       cmd;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] val;
        push_bias = 50;
        pool      = 1;
        base      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty-FIFO corner cases
        send_item(cfsq_pkg::CMD_QUERY, VAL_MAX);
        send_item(cfsq_pkg::CMD_POP, '0);
        send_item(CMD_SPARE, 31'd3);
        // fill to the brim with both extremes and repeats
        for (k = 0; k < FILL_ITEMS; k++)
            send_item(cfsq_pkg::CMD_PUSH,
                      (k == 0) ? VAL_MAX : (k == 1) ? '0 : VAL_W'(k % 4));
        send_item(cfsq_pkg::CMD_PUSH, 31'd9);
        send_item(cfsq_pkg::CMD_QUERY, 31'd2);
        send_item(cfsq_pkg::CMD_QUERY, VAL_MAX);
        send_item(cfsq_pkg::CMD_POP, 31'd0);
        send_item(cfsq_pkg::CMD_PUSH, 31'd2);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            // each block of 50 leans towards filling or draining, around a few keys
            if (k % 50 == 0) begin
                push_bias = $urandom_range(15, 85);
                pool      = 1 << $urandom_range(0, 2);
                base      = VAL_W'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                cmd = (pick < 2) ? CMD_SPARE : cfsq_pkg::CMD_QUERY;
            else if (pick < 8 + (92 * push_bias) / 100)
                cmd = cfsq_pkg::CMD_PUSH;
            else
                cmd = cfsq_pkg::CMD_POP;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                val = base + VAL_W'($urandom_range(0, pool - 1));
            else if (pick < 8)
                val = VAL_W'($urandom);
            else if (pick == 8)
                val = VAL_MAX;
            else
                val = '0;
            send_item(cmd, val);
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : receiver
        int   beats;
        logic held_once;
        beats     = 0;
        held_once = 1'b0;
        wait (rst_n);
        forever begin
            if (beats == HOLD_AT && !held_once) begin
                // long hold-off so the block backs up and drops in_ready
                held_once = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (beats < TAIL_FROM && (beats / 40) % 3 != 1
                         && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid)
                beats++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
